FILE: rtl/core/tcpm_pkg.sv
// Shared definitions for the threshold crossing period meter.
// Register indexes and fixed sizes; no dependencies.
`default_nettype none

package tcpm_pkg;

   localparam int CSR_INDEX_WIDTH = 2;

   // Crossing jobs that can wait between the sample front end and the divider
   localparam int QUEUE_DEPTH = 4;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_THRESHOLD_LEVEL = 2'd0,
      CSR_MEASURE_MODE    = 2'd1,
      CSR_TRIGGER_TIME    = 2'd2
   } csr_index_type;

endpackage

`default_nettype wire

FILE: rtl/core/threshold_crossing_period_meter.sv
// Threshold crossing period meter, top level: register file, sample front end,
// crossing queue and interpolation back end. Uses tcpm_pkg and the tcpm_* modules.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    sample_time, sample_value, record_start
//   rsp      out        rsp_valid/rsp_ready    crossing_time, measured_interval
//   csr      in         csr_valid/csr_ready    csr_index, csr_wdata (always ready)
//
// A sample is taken every cycle while the crossing queue has room.
// Each crossing passes through the back end in order: a start, a multiply,
// TIME_WIDTH restoring divide steps, a sum and a decision.
// The queue holds QUEUE_DEPTH crossings; req_ready drops only when it is full.
// A held result in the output register stalls the back end; the front stalls
// only once the queue has filled behind it.
// Synchronous reset clears history, queue and output valid; no clearing pass.
`default_nettype none

module threshold_crossing_period_meter #(
   parameter int TIME_WIDTH   = 32,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            req_valid,
   output logic                                            req_ready,
   input  logic signed [TIME_WIDTH-1:0]                    req_sample_time,
   input  logic signed [SAMPLE_WIDTH-1:0]                  req_sample_value,
   input  logic                                            req_record_start,
   output logic                                            rsp_valid,
   input  logic                                            rsp_ready,
   output logic signed [TIME_WIDTH-1:0]                    rsp_crossing_time,
   output logic [TIME_WIDTH-1:0]                           rsp_measured_interval,
   input  logic                                            csr_valid,
   output logic                                            csr_ready,
   input  logic [tcpm_pkg::CSR_INDEX_WIDTH-1:0]            csr_index,
   input  logic [((TIME_WIDTH > SAMPLE_WIDTH) ?
                  TIME_WIDTH : SAMPLE_WIDTH)-1:0]          csr_wdata
);
   import tcpm_pkg::*;

   localparam int JOB_WIDTH = 2 * TIME_WIDTH + 2 * SAMPLE_WIDTH + 2;

   logic signed [SAMPLE_WIDTH-1:0] threshold_ff;
   logic                           mode_ff;
   logic signed [TIME_WIDTH-1:0]   trigger_ff;

   logic                 push_valid, push_ready;
   logic [JOB_WIDTH-1:0] push_data;
   logic                 pop_valid, pop_ready;
   logic [JOB_WIDTH-1:0] pop_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= '0;
         mode_ff      <= 1'b0;
         trigger_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD_LEVEL: threshold_ff <= csr_wdata[SAMPLE_WIDTH-1:0];
            CSR_MEASURE_MODE:    mode_ff      <= csr_wdata[0];
            CSR_TRIGGER_TIME:    trigger_ff   <= csr_wdata[TIME_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   tcpm_front #(
      .TIME_WIDTH   (TIME_WIDTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .JOB_WIDTH    (JOB_WIDTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .threshold        (threshold_ff),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_time  (req_sample_time),
      .req_sample_value (req_sample_value),
      .req_record_start (req_record_start),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   tcpm_queue #(
      .WIDTH (JOB_WIDTH),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   tcpm_back #(
      .TIME_WIDTH   (TIME_WIDTH),
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .JOB_WIDTH    (JOB_WIDTH)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .mode                  (mode_ff),
      .trigger               (trigger_ff),
      .pop_valid             (pop_valid),
      .pop_ready             (pop_ready),
      .pop_data              (pop_data),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_crossing_time     (rsp_crossing_time),
      .rsp_measured_interval (rsp_measured_interval)
   );

endmodule

`default_nettype wire

FILE: rtl/core/tcpm_front.sv
// Sample front end: keeps the previous sample, detects rising threshold
// crossings and packs interpolation jobs for the queue. Uses tcpm_pkg.
`default_nettype none

module tcpm_front #(
   parameter int TIME_WIDTH   = 32,
   parameter int SAMPLE_WIDTH = 16,
   parameter int JOB_WIDTH    = 2 * TIME_WIDTH + 2 * SAMPLE_WIDTH + 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic signed [SAMPLE_WIDTH-1:0] threshold,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic signed [TIME_WIDTH-1:0]   req_sample_time,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_value,
   input  logic                           req_record_start,
   output logic                           push_valid,
   input  logic                           push_ready,
   output logic [JOB_WIDTH-1:0]           push_data
);
   import tcpm_pkg::*;

   logic signed [TIME_WIDTH-1:0]   prev_time_ff,  prev_time_in;
   logic signed [SAMPLE_WIDTH-1:0] prev_value_ff, prev_value_in;
   logic                           prev_valid_ff, prev_valid_in;
   logic                           pend_clear_ff, pend_clear_in;

   logic                           accept;
   logic                           hit;
   logic signed [TIME_WIDTH:0]     dt;
   logic signed [SAMPLE_WIDTH:0]   num_wide;
   logic signed [SAMPLE_WIDTH:0]   den_wide;

   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;

   assign hit = prev_valid_ff && !req_record_start &&
                (prev_value_ff < threshold) && (req_sample_value >= threshold);

   assign dt       = {req_sample_time[TIME_WIDTH-1], req_sample_time} -
                     {prev_time_ff[TIME_WIDTH-1], prev_time_ff};
   assign num_wide = {threshold[SAMPLE_WIDTH-1], threshold} -
                     {prev_value_ff[SAMPLE_WIDTH-1], prev_value_ff};
   assign den_wide = {req_sample_value[SAMPLE_WIDTH-1], req_sample_value} -
                     {prev_value_ff[SAMPLE_WIDTH-1], prev_value_ff};

   // Both differences are positive and below 2^SAMPLE_WIDTH on a crossing
   assign push_valid = req_valid && hit;
   assign push_data  = {pend_clear_ff, prev_time_ff, dt,
                        num_wide[SAMPLE_WIDTH-1:0], den_wide[SAMPLE_WIDTH-1:0]};

   always_comb begin
      prev_time_in  = prev_time_ff;
      prev_value_in = prev_value_ff;
      prev_valid_in = prev_valid_ff;
      pend_clear_in = pend_clear_ff;
      if (accept) begin
         prev_time_in  = req_sample_time;
         prev_value_in = req_sample_value;
         prev_valid_in = 1'b1;
         // a record start travels with the next crossing job
         if (req_record_start) begin
            pend_clear_in = 1'b1;
         end else if (hit) begin
            pend_clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_valid_ff <= 1'b0;
         pend_clear_ff <= 1'b0;
      end else begin
         prev_valid_ff <= prev_valid_in;
         pend_clear_ff <= pend_clear_in;
      end
      prev_time_ff  <= prev_time_in;
      prev_value_ff <= prev_value_in;
   end

endmodule

`default_nettype wire

FILE: rtl/core/tcpm_queue.sv
// Small register FIFO that decouples the sample front end from the
// interpolation back end. Uses tcpm_pkg.
`default_nettype none

module tcpm_queue #(
   parameter int WIDTH = 98,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import tcpm_pkg::*;

   localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]     entry_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff,  count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != CNT_WIDTH'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/tcpm_scale.sv
// Iterative scaler: quotient = floor(mag * num / den) with num <= den.
// A multiply step, then one restoring division step per cycle. Uses tcpm_pkg.
`default_nettype none

module tcpm_scale #(
   parameter int MAG_WIDTH = 32,
   parameter int NUM_WIDTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MAG_WIDTH-1:0] mag,
   input  logic [NUM_WIDTH-1:0] num,
   input  logic [NUM_WIDTH-1:0] den,
   output logic                 done,
   output logic [MAG_WIDTH-1:0] quotient
);
   import tcpm_pkg::*;

   localparam int PROD_WIDTH = MAG_WIDTH + NUM_WIDTH;
   localparam int CNT_WIDTH  = (MAG_WIDTH > 1) ? $clog2(MAG_WIDTH) : 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL,
      S_DIV
   } state_type;

   state_type            state_ff;
   logic                 done_ff;
   logic [CNT_WIDTH-1:0] cnt_ff;
   logic [MAG_WIDTH-1:0] mag_ff;
   logic [NUM_WIDTH-1:0] num_ff;
   logic [NUM_WIDTH-1:0] den_ff;
   logic [NUM_WIDTH-1:0] rem_ff;
   logic [MAG_WIDTH-1:0] work_ff;

   logic [PROD_WIDTH-1:0] product;
   logic [NUM_WIDTH:0]    trial;
   logic [NUM_WIDTH:0]    diff;
   logic                  fits;

   assign product = PROD_WIDTH'(mag_ff) * PROD_WIDTH'(num_ff);
   assign trial   = {rem_ff, work_ff[MAG_WIDTH-1]};
   assign diff    = trial - {1'b0, den_ff};
   assign fits    = !diff[NUM_WIDTH];

   assign done     = done_ff;
   assign quotient = work_ff;

   // The quotient never exceeds mag, so the upper product bits start below den
   // and MAG_WIDTH steps are enough.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == S_DIV) && (cnt_ff == '0);
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  mag_ff   <= mag;
                  num_ff   <= num;
                  den_ff   <= den;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               rem_ff   <= product[PROD_WIDTH-1:MAG_WIDTH];
               work_ff  <= product[MAG_WIDTH-1:0];
               cnt_ff   <= CNT_WIDTH'(MAG_WIDTH - 1);
               state_ff <= S_DIV;
            end
            S_DIV: begin
               rem_ff  <= fits ? diff[NUM_WIDTH-1:0] : trial[NUM_WIDTH-1:0];
               work_ff <= {work_ff[MAG_WIDTH-2:0], fits};
               if (cnt_ff == '0) begin
                  state_ff <= S_IDLE;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/tcpm_back.sv
// Crossing back end: interpolates each queued crossing through tcpm_scale,
// applies period or trigger rules and holds the result register. Uses tcpm_pkg.
`default_nettype none

module tcpm_back #(
   parameter int TIME_WIDTH   = 32,
   parameter int SAMPLE_WIDTH = 16,
   parameter int JOB_WIDTH    = 2 * TIME_WIDTH + 2 * SAMPLE_WIDTH + 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         mode,
   input  logic signed [TIME_WIDTH-1:0] trigger,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  logic [JOB_WIDTH-1:0]         pop_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [TIME_WIDTH-1:0] rsp_crossing_time,
   output logic [TIME_WIDTH-1:0]        rsp_measured_interval
);
   import tcpm_pkg::*;

   typedef enum logic [1:0] {
      B_IDLE,
      B_DIV,
      B_EMIT
   } state_type;

   state_type                    state_ff;
   logic                         clear_ff;
   logic                         neg_ff;
   logic signed [TIME_WIDTH-1:0] prev_time_ff;
   logic signed [TIME_WIDTH-1:0] t_ff;
   logic signed [TIME_WIDTH-1:0] last_ff;
   logic                         cv_ff;
   logic                         tr_ff;
   logic                         rsp_valid_ff;
   logic signed [TIME_WIDTH-1:0] rsp_ct_ff;
   logic [TIME_WIDTH-1:0]        rsp_mi_ff;

   // job fields
   logic                         job_clear;
   logic signed [TIME_WIDTH-1:0] job_prev_time;
   logic signed [TIME_WIDTH:0]   job_dt;
   logic [SAMPLE_WIDTH-1:0]      job_num;
   logic [SAMPLE_WIDTH-1:0]      job_den;
   logic [TIME_WIDTH:0]          dt_abs;

   logic                         scale_start;
   logic                         scale_done;
   logic [TIME_WIDTH-1:0]        scale_q;
   logic [TIME_WIDTH:0]          q_ext;
   logic [TIME_WIDTH:0]          t_sum;

   logic                         out_free;
   logic                         cv_eff, tr_eff;
   logic                         emit_period, emit_trigger;

   assign {job_clear, job_prev_time, job_dt, job_num, job_den} = pop_data;
   assign dt_abs = job_dt[TIME_WIDTH] ? -job_dt : job_dt;

   assign pop_ready   = (state_ff == B_IDLE);
   assign scale_start = (state_ff == B_IDLE) && pop_valid;

   tcpm_scale #(
      .MAG_WIDTH (TIME_WIDTH),
      .NUM_WIDTH (SAMPLE_WIDTH)
   ) u_scale (
      .clock    (clock),
      .reset    (reset),
      .start    (scale_start),
      .mag      (dt_abs[TIME_WIDTH-1:0]),
      .num      (job_num),
      .den      (job_den),
      .done     (scale_done),
      .quotient (scale_q)
   );

   // |offset| <= |dt|, so the sum always lands between the two sample times
   assign q_ext = {1'b0, scale_q};
   assign t_sum = {prev_time_ff[TIME_WIDTH-1], prev_time_ff} + (neg_ff ? -q_ext : q_ext);

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign cv_eff       = cv_ff && !clear_ff;
   assign tr_eff       = tr_ff && !clear_ff;
   assign emit_period  = !mode && cv_eff && (t_ff >= last_ff);
   assign emit_trigger = mode && !tr_eff && (t_ff > trigger);

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_crossing_time     = rsp_ct_ff;
   assign rsp_measured_interval = rsp_mi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         cv_ff        <= 1'b0;
         tr_ff        <= 1'b0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // held until taken, or loaded by the decision cycle
         rsp_valid_ff <= (rsp_valid_ff && !rsp_ready) ||
                         ((state_ff == B_EMIT) && out_free &&
                          (emit_period || emit_trigger));
         case (state_ff)
            B_IDLE: begin
               if (pop_valid) begin
                  clear_ff     <= job_clear;
                  prev_time_ff <= job_prev_time;
                  neg_ff       <= job_dt[TIME_WIDTH];
                  state_ff     <= B_DIV;
               end
            end
            B_DIV: begin
               if (scale_done) begin
                  t_ff     <= t_sum[TIME_WIDTH-1:0];
                  state_ff <= B_EMIT;
               end
            end
            B_EMIT: begin
               if (out_free) begin
                  if (emit_period) begin
                     rsp_ct_ff <= t_ff;
                     rsp_mi_ff <= t_ff - last_ff;
                  end else if (emit_trigger) begin
                     rsp_ct_ff <= t_ff;
                     rsp_mi_ff <= t_ff - trigger;
                  end
                  tr_ff    <= tr_eff || emit_trigger;
                  last_ff  <= t_ff;
                  cv_ff    <= 1'b1;
                  state_ff <= B_IDLE;
               end
            end
            default: begin
               state_ff <= B_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/tcpm_checker.sv
// Port-level checks for threshold_crossing_period_meter, bound to the top level.
// No package dependencies.
`default_nettype none

module tcpm_checker #(
   parameter int TIME_WIDTH = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [TIME_WIDTH-1:0] rsp_crossing_time,
   input logic [TIME_WIDTH-1:0] rsp_measured_interval,
   input logic                  csr_ready
);

   // A held result keeps its value until the transaction completes
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_crossing_time) &&
                                  $stable(rsp_measured_interval))
      else $error("rsp transaction changed while stalled");

   // Reset empties the output register and the crossing queue
   a_reset_rsp: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

   a_reset_req: assert property (@(posedge clock)
      $past(reset) |-> req_ready)
      else $error("req_ready low right after reset");

   // A result needs a full interpolation, so none appears straight after reset
   a_rsp_latency: assert property (@(posedge clock)
      reset |=> !rsp_valid ##1 !rsp_valid)
      else $error("rsp transaction too soon after reset");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("csr_ready dropped");

endmodule

bind threshold_crossing_period_meter tcpm_checker #(
   .TIME_WIDTH (TIME_WIDTH)
) u_tcpm_checker (.*);

`default_nettype wire

FILE: sim/tb_threshold_crossing_period_meter.sv
// Testbench for threshold_crossing_period_meter: directed and random waveform records,
// checked against an in-bench crossing predictor. Depends on tcpm_pkg and the RTL only.
`default_nettype none

module tb_threshold_crossing_period_meter;
   import tcpm_pkg::*;

   localparam int TW = 32;
   localparam int SW = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED = 2'd3;
   localparam int DRAIN_CYCLES    = (QUEUE_DEPTH + 2) * (TW + 4) + 24;
   localparam int HOLD_OFF_CYCLES = 600;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int PHASE_ITEMS     = 150;

   typedef struct packed {
      logic [TW-1:0] crossing_time;
      logic [TW-1:0] interval;
   } crossing_result_type;

   logic                          clock;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [TW-1:0]          req_sample_time = '0;
   logic signed [SW-1:0]          req_sample_value = '0;
   logic                          req_record_start = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [TW-1:0]          rsp_crossing_time;
   logic [TW-1:0]                 rsp_measured_interval;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index = '0;
   logic [TW-1:0]                 csr_wdata = '0;

   // Predictor copy of the registers and history
   logic signed [SW-1:0] cfg_threshold = '0;
   logic                 cfg_mode = 1'b0;
   logic signed [TW-1:0] cfg_trigger = '0;
   longint prev_time = 0, prev_value = 0, last_cross = 0;
   bit     prev_valid = 0, cross_valid = 0, trig_done = 0;

   crossing_result_type expected_crossings[$];
   int  mismatch_count = 0;
   int  quiet_cycles = 0;
   int  sink_hold_cycles = 0;
   bit  source_idling = 1'b1;
   bit  sink_idling = 1'b1;

   threshold_crossing_period_meter DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_sample_time       (req_sample_time),
      .req_sample_value      (req_sample_value),
      .req_record_start      (req_record_start),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_crossing_time     (rsp_crossing_time),
      .rsp_measured_interval (rsp_measured_interval),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < 50) $display("MISMATCH at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // dt * num / den, truncated toward zero; 0 < num <= den
   function automatic longint scaled_offset(longint dt, longint num, longint den);
      longint unsigned mag, n, d, q;
      n = num;
      d = den;
      mag = (dt < 0) ? -dt : dt;
      q = (mag / d) * n + ((mag % d) * n) / d;
      if (dt < 0) return -longint'(q);
      return longint'(q);
   endfunction

   function automatic void predict_crossing(logic [TW-1:0] t_raw, logic [SW-1:0] v_raw,
                                            logic start);
      longint t_now, v_now, thr, t_cross;
      crossing_result_type r;
      t_now = $signed(t_raw);
      v_now = $signed(v_raw);
      thr = cfg_threshold;
      if (start) begin
         prev_valid = 0;
         cross_valid = 0;
         trig_done = 0;
      end
      if (prev_valid && prev_value < thr && v_now >= thr) begin
         t_cross = prev_time + scaled_offset(t_now - prev_time, thr - prev_value,
                                             v_now - prev_value);
         if (!cfg_mode) begin
            // backwards crossings are dropped but still become the reference
            if (cross_valid && t_cross >= last_cross) begin
               r.crossing_time = t_cross[TW-1:0];
               r.interval = t_cross[TW-1:0] - last_cross[TW-1:0];
               expected_crossings = {expected_crossings, r};
            end
         end else if (!trig_done && t_cross > cfg_trigger) begin
            r.crossing_time = t_cross[TW-1:0];
            r.interval = t_cross[TW-1:0] - cfg_trigger;
            expected_crossings = {expected_crossings, r};
            trig_done = 1;
         end
         last_cross = t_cross;
         cross_valid = 1;
      end
      prev_time = t_now;
      prev_value = v_now;
      prev_valid = 1;
   endfunction

   always @(posedge clock) begin : monitor
      crossing_result_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_THRESHOLD_LEVEL: cfg_threshold = csr_wdata[SW-1:0];
               CSR_MEASURE_MODE:    cfg_mode = csr_wdata[0];
               CSR_TRIGGER_TIME:    cfg_trigger = csr_wdata[TW-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_crossing(req_sample_time, req_sample_value, req_record_start);
         if (rsp_valid && rsp_ready) begin
            if (expected_crossings.size() == 0) begin
               report_mismatch($sformatf("unexpected result time=%h interval=%h",
                                         rsp_crossing_time, rsp_measured_interval));
            end else begin
               want = expected_crossings.pop_front();
               if (rsp_crossing_time !== want.crossing_time)
                  report_mismatch($sformatf("crossing_time %h, expected %h",
                                            rsp_crossing_time, want.crossing_time));
               if (rsp_measured_interval !== want.interval)
                  report_mismatch($sformatf("measured_interval %h, expected %h",
                                            rsp_measured_interval, want.interval));
            end
         end
      end
   end

   // Watchdog: any transaction on any channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : result_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (sink_hold_cycles > 0) begin
            rsp_ready = 1'b0;
            sink_hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (sink_idling && $urandom_range(0, 9) == 0) begin
            rsp_ready = 1'b0;
            stall_left = $urandom_range(0, 11);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   task automatic send_sample(input logic [TW-1:0] t, input logic signed [SW-1:0] v,
                              input logic start);
      int gap;
      if (source_idling && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_sample_time = t;
      req_sample_value = v;
      req_record_start = start;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [TW-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Back end may still be busy with crossings that give no result
   task automatic drain_block();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_crossings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic configure(input logic signed [SW-1:0] thr, input logic mode,
                            input logic [TW-1:0] trig);
      drain_block();
      write_register(CSR_THRESHOLD_LEVEL, {16'($urandom), thr});
      write_register(CSR_MEASURE_MODE, {31'($urandom), mode});
      write_register(CSR_TRIGGER_TIME, trig);
   endtask

   task automatic test_period_directed();
      configure(16'sd100, 1'b0, '0);
      send_sample(32'h0000_0000, -16'sd32768, 1'b1);
      send_sample(32'h0000_0100, 16'sd32767, 1'b0);   // first crossing: stored only
      send_sample(32'h0000_0200, -16'sd5, 1'b0);
      send_sample(32'h0000_0300, 16'sd200, 1'b0);
      send_sample(32'h0000_0100, 16'sd0, 1'b0);
      send_sample(32'h0000_0180, 16'sd150, 1'b0);     // earlier than last: dropped
      send_sample(32'h0000_0100, 16'sd50, 1'b0);
      send_sample(32'h0000_0155, 16'sd100, 1'b0);     // same time again: zero interval
      send_sample(32'h0000_1000, -16'sd100, 1'b0);
      send_sample(32'h0000_0F00, 16'sd300, 1'b0);     // time runs backwards across edge
      send_sample(32'h0000_1100, 16'sd100, 1'b0);
      send_sample(32'h0000_1200, 16'sd200, 1'b0);     // starts at threshold: no crossing
      send_sample(32'h0000_2000, -16'sd100, 1'b1);
      send_sample(32'h0000_2100, 16'sd500, 1'b1);     // record start never crosses
      send_sample(32'h0000_2200, -16'sd100, 1'b0);
      send_sample(32'h0000_2300, 16'sd500, 1'b0);
      send_sample(32'h0000_2400, -16'sd1, 1'b0);
      send_sample(32'h0000_2500, 16'sd100, 1'b0);
      send_sample(32'h8000_0000, -16'sd32768, 1'b1);
      send_sample(32'h7FFF_FFFF, 16'sd32767, 1'b0);
      send_sample(32'h8000_0000, -16'sd32768, 1'b0);
      send_sample(32'h7FFF_FFFF, 16'sd100, 1'b0);
   endtask

   task automatic test_trigger_directed();
      configure(16'sd100, 1'b1, 32'h0000_1000);
      send_sample(32'h0000_0000, -16'sd10, 1'b1);
      send_sample(32'h0000_0100, 16'sd200, 1'b0);     // before trigger
      send_sample(32'h0000_0F00, 16'sd0, 1'b0);
      send_sample(32'h0000_1100, 16'sd200, 1'b0);     // exactly at trigger: not counted
      send_sample(32'h0000_1200, 16'sd0, 1'b0);
      send_sample(32'h0000_1300, 16'sd200, 1'b0);
      send_sample(32'h0000_1400, 16'sd0, 1'b0);
      send_sample(32'h0000_1500, 16'sd200, 1'b0);     // already reported this record
      send_sample(32'h0000_1600, 16'sd0, 1'b1);
      send_sample(32'h0000_1700, 16'sd200, 1'b0);
      // switch to period mode inside the record; last crossing carries over
      drain_block();
      write_register(CSR_MEASURE_MODE, '0);
      send_sample(32'h0000_1800, 16'sd0, 1'b0);
      send_sample(32'h0000_1900, 16'sd200, 1'b0);
      configure(16'sd100, 1'b1, 32'hFFFF_F000);
      send_sample(32'hFFFF_E000, -16'sd50, 1'b1);
      send_sample(32'hFFFF_F800, 16'sd150, 1'b0);
   endtask

   task automatic test_unmapped_register();
      drain_block();
      write_register(CSR_UNMAPPED, $urandom);
      send_sample(32'h0000_0000, -16'sd200, 1'b1);
      send_sample(32'h0000_0040, 16'sd300, 1'b0);
      send_sample(32'h0000_0080, -16'sd200, 1'b0);
      send_sample(32'h0000_00C0, 16'sd300, 1'b0);
   endtask

   // Receiver holds off while a square wave fills the crossing queue
   task automatic test_input_stall();
      int i;
      configure(16'sd0, 1'b0, '0);
      source_idling = 1'b0;
      sink_hold_cycles = HOLD_OFF_CYCLES;
      for (i = 0; i < 48; i++)
         send_sample(i * 32'h40, (i % 2) ? 16'sd1000 : -16'sd1000, i == 0);
      source_idling = 1'b1;
   endtask

   task automatic run_waveform_phase(input int item_total);
      int sent, k, period, rec_left;
      longint lo, hi, thr, value;
      logic [TW-1:0] t_cur, step;
      logic start;
      thr = cfg_threshold;
      rec_left = 0;
      k = 0;
      period = 2;
      lo = -32768;
      hi = 32767;
      step = 32'h100;
      t_cur = $urandom;
      for (sent = 0; sent < item_total; sent++) begin
         if ($urandom_range(0, 15) == 0) begin
            send_sample($urandom, 16'($urandom), 1'($urandom_range(0, 1)));
         end else begin
            start = 1'b0;
            if (rec_left == 0) begin
               start = 1'b1;
               rec_left = $urandom_range(8, 80);
               period = $urandom_range(2, 12);
               k = $urandom_range(0, period - 1);
               if (thr == -32768) lo = -32768;
               else if ($urandom_range(0, 3) == 0) lo = -32768;
               else if ($urandom_range(0, 2) == 0) lo = thr - $urandom_range(1, 50);
               else lo = thr - 1 - $urandom_range(0, thr + 32767);
               if (lo < -32768) lo = -32768;
               if ($urandom_range(0, 3) == 0) hi = 32767;
               else if ($urandom_range(0, 2) == 0) hi = thr + $urandom_range(0, 50);
               else hi = thr + $urandom_range(0, 32767 - thr);
               if (hi > 32767) hi = 32767;
               case ($urandom_range(0, 15))
                  0:       step = '0;
                  1, 2:    step = $urandom;
                  3:       step = -$urandom_range(1, 'h400);
                  default: step = $urandom_range(1, 'h800);
               endcase
               if ($urandom_range(0, 3) == 0) t_cur = $urandom;
            end
            value = lo + (hi - lo) * k / (period - 1);
            if ($urandom_range(0, 7) == 0) value = value + $urandom_range(0, 200) - 100;
            if (value > 32767) value = 32767;
            if (value < -32768) value = -32768;
            send_sample(t_cur, value[SW-1:0], start);
            t_cur = t_cur + step;
            k = (k + 1) % period;
            rec_left--;
         end
      end
   endtask

   task automatic test_random_waveforms();
      int phase;
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: configure(16'sd0, 1'b0, '0);
            1: configure(-16'sd32768, 1'b0, $urandom);
            2: configure(16'sd32767, 1'b0, $urandom);
            3: configure(16'($urandom), 1'b1, $urandom);
            4: configure(16'($urandom), 1'b1, 32'h7FFF_FFFF);
            5: configure(16'($urandom), 1'b1, 32'h8000_0000);
            6: configure(16'($urandom), 1'b0, $urandom);
            default: begin
               configure(16'($urandom), 1'b0, '0);
               source_idling = 1'b0;
               sink_idling = 1'b0;
            end
         endcase
         run_waveform_phase(PHASE_ITEMS);
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_period_directed();
      test_trigger_directed();
      test_unmapped_register();
      test_input_stall();
      test_random_waveforms();
      drain_block();
      if (expected_crossings.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_crossings.size()));
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/core/tcpm_pkg.sv
rtl/core/tcpm_front.sv
rtl/core/tcpm_queue.sv
rtl/core/tcpm_scale.sv
rtl/core/tcpm_back.sv
rtl/core/threshold_crossing_period_meter.sv
rtl/core/tcpm_checker.sv
sim/tb_threshold_crossing_period_meter.sv
